>>> hw/rtl/bdtpe_pkg.sv
// ----------------------------------------------------------------------------
// bdtpe_pkg
// Shared types, constants and codes of the device table people estimator.
// ----------------------------------------------------------------------------
package bdtpe_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int AVG_LEVELS  = 256;

   localparam logic [15:0] HIT_MAX     = 16'hFFFF;
   localparam int          PEOPLE_MAX  = 16383;
   localparam int          ENTRIES_MAX = 127;

   // request function codes
   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_REPORT   = 2'd1;
   localparam logic [1:0] FUNC_ESTIMATE = 2'd2;

   // response status codes
   localparam logic [2:0] STATUS_CLEARED = 3'd0;
   localparam logic [2:0] STATUS_IGNORED = 3'd1;
   localparam logic [2:0] STATUS_UPDATED = 3'd2;
   localparam logic [2:0] STATUS_ADDED   = 3'd3;
   localparam logic [2:0] STATUS_DONE    = 3'd4;

   // register indexes
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_MIN_HITS  = 2'd1;
   localparam logic [1:0] REG_MERGE_GAP = 2'd2;
   localparam logic [1:0] REG_GAIN      = 2'd3;

   localparam logic signed [7:0] THRESHOLD_RESET = -8'sd65;
   localparam logic [15:0]       MIN_HITS_RESET  = 16'd12;
   localparam logic [7:0]        MERGE_GAP_RESET = 8'd3;
   localparam logic [15:0]       GAIN_RESET      = 16'd256;

   typedef struct packed {
      logic [1:0]         func;
      logic [47:0]        mac;
      logic signed [7:0]  rssi;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  entries;
      logic [13:0] people;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        mac;
      logic [15:0]        hits;
      logic signed [23:0] total;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EST_RD,
      S_EST_CHK,
      S_EST_DIV,
      S_WALK,
      S_WALK_LAST,
      S_SCALE,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/ble_device_table_people_estimator_core.sv
// Clear, weak report and unused code pass through the done state to the response register.
// Report: walks the table entries, one RAM read and one compare per entry walked.
// Estimate: a read and a check per entry, a serial division for each entry that qualifies,
// then a walk over the average map and a scaling step.
// One request is in work at a time; a new one is taken while a response waits.
// Reset (sync, active high) empties the table, loads defaults and clears the map.
// ----------------------------------------------------------------------------
// ble_device_table_people_estimator_core
// Device address table with hit counts and RSSI sums in one RAM, and a
// cluster based people estimate over the per-entry average RSSI.
// ----------------------------------------------------------------------------
module ble_device_table_people_estimator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdtpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdtpe_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bdtpe_pkg::*;

   localparam int EW = (CNT_W > 7) ? CNT_W : 7;
   localparam int PW = CNT_W + 16;

   // configuration registers
   logic signed [7:0] thresh_ff;
   logic [15:0]       min_hits_ff;
   logic [7:0]        gap_ff;
   logic [15:0]       gain_ff;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [2:0]        status_ff, status_in;
   logic [13:0]       people_ff, people_in;
   logic [7:0]        walk_ff, walk_in;
   logic              rd_ok_ff, rd_ok_in;
   logic signed [7:0] head_ff, head_in;
   logic              head_ok_ff, head_ok_in;
   logic [CNT_W-1:0]  clusters_ff, clusters_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   entry_type         ram_wdata, ram_rdata;
   logic              seen_we;
   logic [7:0]        seen_waddr, seen_raddr;
   logic              seen_wdata, seen_rdata;
   logic              div_start, div_done;
   logic signed [7:0] div_q;
   logic [PW-1:0]     product;
   logic [7:0]        prev_lvl;
   logic signed [9:0] head_dist;
   logic              open_head;
   logic [EW-1:0]     count_ext;

   bdtpe_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // one flag per average level, offset binary address
   bdtpe_ram #(.WIDTH(1), .DEPTH(AVG_LEVELS)) u_seen (
      .clock (clock),
      .we    (seen_we),
      .waddr (seen_waddr),
      .wdata (seen_wdata),
      .raddr (seen_raddr),
      .rdata (seen_rdata)
   );

   bdtpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rdata.total),
      .divisor  (ram_rdata.hits),
      .done     (div_done),
      .quotient (div_q)
   );

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESHOLD_RESET;
         min_hits_ff <= MIN_HITS_RESET;
         gap_ff      <= MERGE_GAP_RESET;
         gain_ff     <= GAIN_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_THRESHOLD: thresh_ff   <= pwdata[7:0];
            REG_MIN_HITS:  min_hits_ff <= pwdata[15:0];
            REG_MERGE_GAP: gap_ff      <= pwdata[7:0];
            REG_GAIN:      gain_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (paddr[3:2])
         REG_THRESHOLD: prdata = {24'd0, thresh_ff};
         REG_MIN_HITS:  prdata = {16'd0, min_hits_ff};
         REG_MERGE_GAP: prdata = {24'd0, gap_ff};
         REG_GAIN:      prdata = {16'd0, gain_ff};
         default:       prdata = 32'd0;
      endcase
   end

   assign pready    = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign product   = PW'(clusters_ff) * PW'(gain_ff);
   // level read in the previous walk cycle
   assign prev_lvl  = walk_ff + 8'd1;
   assign head_dist = 10'(head_ff) - 10'(signed'(prev_lvl ^ 8'h80));
   assign open_head = rd_ok_ff && seen_rdata &&
                      (!head_ok_ff || head_dist > 10'(gap_ff));
   assign count_ext = EW'(count_ff);

   // sequencer: map clear after reset, table scan, estimate pass, response hand-off
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      people_in    = people_ff;
      walk_in      = walk_ff;
      rd_ok_in     = rd_ok_ff;
      head_in      = head_ff;
      head_ok_in   = head_ok_ff;
      clusters_in  = clusters_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[IDX_W-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff[IDX_W-1:0];
      seen_we      = 1'b0;
      seen_waddr   = walk_ff;
      seen_wdata   = 1'b0;
      seen_raddr   = walk_ff;
      div_start    = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // clear the average map once after reset
            seen_we = 1'b1;
            walk_in = walk_ff - 8'd1;
            if (walk_ff == 8'd0) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               idx_in    = '0;
               people_in = 14'd0;
               state_in  = S_DONE;
               case (req_data.func)
                  FUNC_CLEAR: begin
                     count_in  = '0;
                     status_in = STATUS_CLEARED;
                  end
                  FUNC_REPORT: begin
                     if (req_data.rssi < thresh_ff) begin
                        status_in = STATUS_IGNORED;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  FUNC_ESTIMATE: begin
                     status_in = STATUS_DONE;
                     state_in  = S_EST_RD;
                  end
                  default: status_in = STATUS_IGNORED;
               endcase
            end
         end
         S_SCAN_RD: begin
            // end of table: append if room
            if (idx_ff == count_ff) begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  ram_we          = 1'b1;
                  ram_wdata.mac   = req_ff.mac;
                  ram_wdata.hits  = 16'd1;
                  ram_wdata.total = 24'(req_ff.rssi);
                  count_in        = count_ff + 1'b1;
                  status_in       = STATUS_ADDED;
               end else begin
                  status_in = STATUS_DONE;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (ram_rdata.mac == req_ff.mac) begin
               // saturated entries keep count and sum
               if (ram_rdata.hits != HIT_MAX) begin
                  ram_we          = 1'b1;
                  ram_wdata.hits  = ram_rdata.hits + 16'd1;
                  ram_wdata.total = ram_rdata.total + 24'(req_ff.rssi);
               end
               status_in = STATUS_UPDATED;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_EST_RD: begin
            if (idx_ff == count_ff) begin
               walk_in     = 8'hFF;
               rd_ok_in    = 1'b0;
               head_ok_in  = 1'b0;
               clusters_in = '0;
               state_in    = S_WALK;
            end else begin
               state_in = S_EST_CHK;
            end
         end
         S_EST_CHK: begin
            if (ram_rdata.hits >= min_hits_ff) begin
               div_start = 1'b1;
               state_in  = S_EST_DIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_EST_RD;
            end
         end
         S_EST_DIV: begin
            // mark the average, offset binary address
            if (div_done) begin
               seen_we    = 1'b1;
               seen_waddr = div_q ^ 8'h80;
               seen_wdata = 1'b1;
               idx_in     = idx_ff + 1'b1;
               state_in   = S_EST_RD;
            end
         end
         S_WALK: begin
            // read and clear one level, judge the level read last cycle
            seen_we = 1'b1;
            if (open_head) begin
               clusters_in = clusters_ff + 1'b1;
               head_in     = prev_lvl ^ 8'h80;
               head_ok_in  = 1'b1;
            end
            rd_ok_in = 1'b1;
            walk_in  = walk_ff - 8'd1;
            if (walk_ff == 8'd0) begin
               state_in = S_WALK_LAST;
            end
         end
         S_WALK_LAST: begin
            // judge the weakest level
            if (open_head) begin
               clusters_in = clusters_ff + 1'b1;
               head_in     = prev_lvl ^ 8'h80;
               head_ok_in  = 1'b1;
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if ((product >> 8) > PW'(PEOPLE_MAX)) begin
               people_in = 14'(PEOPLE_MAX);
            end else begin
               people_in = product[21:8];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand off when the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = status_ff;
               rsp_in.people  = people_ff;
               rsp_in.entries = (count_ext > EW'(ENTRIES_MAX)) ?
                                7'(ENTRIES_MAX) : count_ext[6:0];
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         walk_ff      <= 8'hFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      people_ff   <= people_in;
      rd_ok_ff    <= rd_ok_in;
      head_ff     <= head_in;
      head_ok_ff  <= head_ok_in;
      clusters_ff <= clusters_in;
      rsp_ff      <= rsp_in;
   end

   a_we_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN_RD || state_ff == S_SCAN_CHK))
      else $error("table written outside a report scan");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count past depth");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.func == FUNC_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the table");
   a_div_only_estimate: assert property (@(posedge clock) disable iff (reset)
      div_start |-> state_ff == S_EST_CHK) else $error("divider started outside estimate");

endmodule

>>> hw/rtl/bdtpe_ram.sv
// ----------------------------------------------------------------------------
// bdtpe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bdtpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/bdtpe_div.sv
// ----------------------------------------------------------------------------
// bdtpe_div
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module bdtpe_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [23:0] dividend,
   input  logic [15:0]        divisor,
   output logic               done,
   output logic signed [7:0]  quotient
);

   logic        busy_ff, busy_in;
   logic [4:0]  step_ff, step_in;
   logic [16:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[23]};
      // load magnitude and sign
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 17'd0;
         quo_in  = dividend[23] ? 24'(-dividend) : 24'(dividend);
         dvs_in  = divisor;
         neg_in  = dividend[23];
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // magnitude never exceeds 128, so eight bits carry the signed result
   assign done     = done_ff;
   assign quotient = neg_ff ? 8'(-quo_ff[7:0]) : quo_ff[7:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("divider done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("divider done held two cycles");

endmodule
